// ===== hdl/kpd_pkg.sv =====
// Shared constants, types and result layout for the keyboard packet decoder.
package kpd_pkg;

    // Frame geometry
    localparam int FRAME_LEN = 8;
    localparam int POS_W     = $clog2(FRAME_LEN);

    // Frame byte positions
    localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SUM_LO = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CMD    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ZOOM   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CAMERA = POS_W'(4);
    localparam logic [POS_W-1:0] POS_PAN    = POS_W'(5);
    localparam logic [POS_W-1:0] POS_TILT   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_SUM_HI = POS_W'(5);

    // Byte codes
    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] CMD_SWITCH    = 8'h11;
    localparam logic [7:0] CMD_PTZ       = 8'h21;
    localparam logic [7:0] CMD_REGISTER  = 8'h41;
    localparam logic [7:0] ZOOM_IN_CODE  = 8'h40;
    localparam logic [7:0] ZOOM_OUT_CODE = 8'h80;
    localparam logic [6:0] STEP_MASK     = 7'h7F;

    // PTZ flag bit positions
    localparam int FLAG_STOP     = 0;
    localparam int FLAG_ZOOM_IN  = 1;
    localparam int FLAG_ZOOM_OUT = 2;
    localparam int FLAG_LEFT     = 3;
    localparam int FLAG_RIGHT    = 4;
    localparam int FLAG_UP       = 5;
    localparam int FLAG_DOWN     = 6;

    // Output beat width: 42 payload bits padded to 48
    localparam int RESULT_BITS = 42;
    localparam int M_DATA_W    = 48;

    typedef enum logic [1:0] {
        MSG_SWITCH  = 2'd0,
        MSG_PTZ     = 2'd1,
        MSG_UNKNOWN = 2'd2
    } msg_type_t;

    // Captured frame fields handed to the decoder
    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] zoom;
        logic [7:0] camera;
        logic [7:0] pan;
        logic [7:0] tilt;
        logic [7:0] sum;
        logic [7:0] check;
        logic       locked;
    } frame_t;

    // Decoded result
    typedef struct packed {
        logic       deliver;
        logic       register_request;
        logic       checksum_ok;
        logic [6:0] tilt_step;
        logic [6:0] pan_step;
        logic [6:0] ptz_flags;
        logic [7:0] monitor_number;
        logic [7:0] camera_number;
        msg_type_t  message_type;
    } result_t;

endpackage

// ===== hdl/kpd_decode.sv =====
// Combinational decode of one captured keyboard frame into a result.
module kpd_decode
    import kpd_pkg::*;
(
    input  frame_t  frame,
    output result_t result
);

    logic       is_switch;
    logic       is_ptz;
    logic [6:0] pan_mag;
    logic [6:0] tilt_mag;
    logic [6:0] flags;

    assign is_switch = (frame.cmd == CMD_SWITCH);
    assign is_ptz    = (frame.cmd == CMD_PTZ);
    assign pan_mag   = frame.pan[6:0] & STEP_MASK;
    assign tilt_mag  = frame.tilt[6:0] & STEP_MASK;

    // Build PTZ flags; a sign-only step gives no direction
    always_comb begin
        flags = '0;
        flags[FLAG_STOP]     = (frame.zoom == 8'd0) && (frame.pan == 8'd0)
                               && (frame.tilt == 8'd0);
        flags[FLAG_ZOOM_IN]  = (frame.zoom == ZOOM_IN_CODE);
        flags[FLAG_ZOOM_OUT] = (frame.zoom == ZOOM_OUT_CODE);
        flags[FLAG_LEFT]     = (pan_mag != 7'd0) && !frame.pan[7];
        flags[FLAG_RIGHT]    = (pan_mag != 7'd0) && frame.pan[7];
        flags[FLAG_UP]       = (tilt_mag != 7'd0) && !frame.tilt[7];
        flags[FLAG_DOWN]     = (tilt_mag != 7'd0) && frame.tilt[7];
    end

    // Select fields by command
    always_comb begin
        result.camera_number    = frame.camera;
        result.checksum_ok      = (frame.sum == frame.check);
        result.register_request = (frame.cmd == CMD_REGISTER);
        result.deliver          = !frame.locked;
        result.monitor_number   = is_switch ? frame.pan : 8'd0;
        result.ptz_flags        = is_ptz ? flags : 7'd0;
        result.pan_step         = is_ptz ? pan_mag : 7'd0;
        result.tilt_step        = is_ptz ? tilt_mag : 7'd0;
        if (is_switch) begin
            result.message_type = MSG_SWITCH;
        end else if (is_ptz) begin
            result.message_type = MSG_PTZ;
        end else begin
            result.message_type = MSG_UNKNOWN;
        end
    end

endmodule

// ===== hdl/keyboard_packet_decoder_top.sv =====
// Top level of the keyboard packet decoder: byte capture, framing and result register.
//
//  Channel   Dir  Width  Contents
//  s_*       in   8      rx_byte, one received serial byte per beat
//  m_*       out  48     decoded frame result, one beat per complete frame
//  cfg_*     in   1      locked register write
//
// One byte per cycle sustained unless stalled: a byte lands in the input
// register, then is framed and (on the last frame byte) decoded into the output
// register. The input register stalls only when it holds a last frame byte
// while the output register is full and not being taken. Reset (aresetn low,
// synchronous) drops any partial frame and returns to sync hunting; locked
// clears to 0.
module keyboard_packet_decoder_top
    import kpd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // [1:0] message_type, [9:2] camera_number, [17:10] monitor_number,
    // [24:18] ptz_flags, [31:25] pan_step, [38:32] tilt_step,
    // [39] checksum_ok, [40] register_request, [41] deliver, [47:42] zero
    output logic [M_DATA_W-1:0] m_tdata,
    // Configuration
    input  logic                cfg_we,
    input  logic                cfg_wdata  // locked
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             locked_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       cmd_reg;
    logic [7:0]       zoom_reg;
    logic [7:0]       camera_reg;
    logic [7:0]       pan_reg;
    logic [7:0]       tilt_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic             is_last;
    logic             advance;
    frame_t           frame;
    result_t          decoded;

    assign is_last  = (pos_reg == POS_LAST);
    assign advance  = in_valid_reg && (!is_last || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold the incoming byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Lock register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg <= 1'b0;
        end else if (cfg_we) begin
            locked_reg <= cfg_wdata;
        end
    end

    // Advance frame position: hunt for sync, then count seven bytes
    always_comb begin
        if (pos_reg == POS_HUNT) begin
            pos_next = (in_byte_reg == SYNC_BYTE) ? POS_SUM_LO : POS_HUNT;
        end else if (is_last) begin
            pos_next = POS_HUNT;
        end else begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
            sum_reg <= 8'd0;
        end else if (advance) begin
            pos_reg <= pos_next;
            if (pos_reg == POS_HUNT) begin
                sum_reg <= 8'd0;
            end else if (pos_reg >= POS_SUM_LO && pos_reg <= POS_SUM_HI) begin
                sum_reg <= sum_reg + in_byte_reg;
            end
        end
    end

    // Capture frame bytes at their positions
    always_ff @(posedge aclk) begin
        if (advance) begin
            case (pos_reg)
                POS_CMD:    cmd_reg    <= in_byte_reg;
                POS_ZOOM:   zoom_reg   <= in_byte_reg;
                POS_CAMERA: camera_reg <= in_byte_reg;
                POS_PAN:    pan_reg    <= in_byte_reg;
                POS_TILT:   tilt_reg   <= in_byte_reg;
                default:    ;
            endcase
        end
    end

    // Decode with the checksum byte taken straight from the input register
    always_comb begin
        frame.cmd    = cmd_reg;
        frame.zoom   = zoom_reg;
        frame.camera = camera_reg;
        frame.pan    = pan_reg;
        frame.tilt   = tilt_reg;
        frame.sum    = sum_reg;
        frame.check  = in_byte_reg;
        frame.locked = locked_reg;
    end

    kpd_decode u_decode (
        .frame  (frame),
        .result (decoded)
    );

    // Result register: load on the last frame byte, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_last) begin
            out_reg <= decoded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - RESULT_BITS)'(0),
                       out_reg.deliver,
                       out_reg.register_request,
                       out_reg.checksum_ok,
                       out_reg.tilt_step,
                       out_reg.pan_step,
                       out_reg.ptz_flags,
                       out_reg.monitor_number,
                       out_reg.camera_number,
                       out_reg.message_type};

endmodule

// ===== hdl/kpd_checker.sv =====
// Port-level checks on the keyboard packet decoder result stream.
module kpd_port_checks
    import kpd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Padding bits stay zero and message type is never the unused code
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:RESULT_BITS] == '0) && (m_tdata[1:0] != 2'd3))
        else $error("bad padding or message type");

    // Stop excludes every other PTZ flag and any step
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |->
            (m_tdata[24:19] == 6'd0) && (m_tdata[38:25] == 14'd0))
        else $error("stop combined with motion");

    // Non-PTZ results carry no flags or steps
    a_non_ptz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != MSG_PTZ) |-> (m_tdata[38:18] == 21'd0))
        else $error("PTZ fields set on non-PTZ result");

    // Only a switch carries a monitor number
    a_monitor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != MSG_SWITCH) |-> (m_tdata[17:10] == 8'd0))
        else $error("monitor number on non-switch result");

endmodule

bind keyboard_packet_decoder_top kpd_port_checks u_kpd_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
